@@ src/rft_pkg.sv @@
// shared types and constants for the rail fence transposition block
package rft_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RailsW  = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_RAILS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIR   = 2'd1;

  localparam logic [RailsW-1:0] RAILS_RESET = 7'd2;

  // job description handed from the front to the back
  typedef struct packed {
    logic              ovf;
    logic [RailsW-1:0] rails;
    logic              dir;
  } job_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAT = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_e;

endpackage

@@ src/rft_ram.sv @@
// generic single write port ram with a registered read port
module rft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/rft_front.sv @@
// front end: config registers, byte loading and job hand-off
module rft_front #(
  parameter int unsigned MaxLen = 64,
  parameter int unsigned LenW   = $clog2(MaxLen + 1),
  parameter int unsigned AddrW  = $clog2(MaxLen)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rft_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        in_last_i,
  input  logic                        cfg_we_i,
  input  logic [rft_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rft_pkg::RailsW-1:0]  cfg_wdata_i,
  input  logic                        q_full_i,
  input  logic                        bank_i,
  output logic                        push_o,
  output logic [LenW-1:0]             len_o,
  output rft_pkg::job_ctrl_t          ctrl_o,
  output logic                        store_we_o,
  output logic [AddrW:0]              store_waddr_o,
  output logic [rft_pkg::ByteW-1:0]   store_wdata_o
);
  import rft_pkg::*;

  logic [RailsW-1:0] rails_q;
  logic              dir_q;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic              room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rails_q <= RAILS_RESET;
      dir_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RAILS: rails_q <= cfg_wdata_i;
        CFG_DIR:   dir_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy   = q_full_i;
  assign accept = start && !q_full_i;
  assign room   = cnt_q < LenW'(MaxLen);

  assign store_we_o    = accept && room;
  assign store_waddr_o = {bank_i, cnt_q[AddrW-1:0]};
  assign store_wdata_o = in_byte_i;

  assign push_o       = accept && in_last_i;
  assign len_o        = room ? cnt_q + LenW'(1) : cnt_q;
  assign ctrl_o.ovf   = ovf_q || !room;
  // zero rails behaves as a single rail
  assign ctrl_o.rails = (rails_q == '0) ? RailsW'(1) : rails_q;
  assign ctrl_o.dir   = dir_q;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

@@ src/rft_job_queue.sv @@
// two-entry job queue, one entry per message buffer bank
module rft_job_queue #(
  parameter int unsigned LenW = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [LenW-1:0]    len_i,
  input  rft_pkg::job_ctrl_t ctrl_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output logic [LenW-1:0]    len_o,
  output rft_pkg::job_ctrl_t ctrl_o,
  output logic               wr_bank_o,
  output logic               rd_bank_o
);
  import rft_pkg::*;

  logic [LenW-1:0] len_q  [2];
  job_ctrl_t       ctrl_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign full_o    = cnt_q[1];
  assign valid_o   = cnt_q != 2'd0;
  assign len_o     = len_q[rd_ptr_q];
  assign ctrl_o    = ctrl_q[rd_ptr_q];
  assign wr_bank_o = wr_ptr_q;
  assign rd_bank_o = rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      len_q[wr_ptr_q]  <= len_i;
      ctrl_q[wr_ptr_q] <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/rft_back.sv @@
// back end: zigzag order walker, decode scatter pass and result emission
module rft_back #(
  parameter int unsigned MaxLen = 64,
  parameter int unsigned LenW   = $clog2(MaxLen + 1),
  parameter int unsigned AddrW  = $clog2(MaxLen)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  logic [LenW-1:0]           len_i,
  input  rft_pkg::job_ctrl_t        ctrl_i,
  input  logic                      bank_i,
  output logic                      pop_o,
  output logic [AddrW:0]            store_raddr_o,
  input  logic [rft_pkg::ByteW-1:0] store_rdata_i,
  output logic                      out_strobe_o,
  output logic [rft_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_last_o,
  output logic                      truncated_o
);
  import rft_pkg::*;

  localparam int unsigned PosW = ((AddrW > 8) ? AddrW : 8) + 1;

  back_state_e       state_q, state_d;
  logic [LenW-1:0]   k_q, k_d;
  logic [RailsW-1:0] rail_q, rail_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic              phase_q, phase_d;
  logic              wr_en_q, wr_en_d;
  logic [AddrW-1:0]  wr_pos_q;
  logic              out_v_q, out_v_d;
  logic              out_last_q, out_trunc_q, out_dir_q;
  logic              last_k;
  logic [AddrW-1:0]  res_raddr;
  logic [ByteW-1:0]  res_rdata;

  // zigzag walker: next message position in rail-major order
  logic [RailsW-1:0] rm1;
  logic [7:0]        cyc, step_a, step_b, step;
  logic [PosW-1:0]   sum;
  logic              wrap;
  logic              advance;

  always_comb begin
    rm1    = ctrl_i.rails - RailsW'(1);
    cyc    = {rm1, 1'b0};
    step_a = {rm1 - rail_q, 1'b0};
    step_b = {rail_q, 1'b0};
    if (cyc == 8'd0) begin
      step = 8'd1;
    end else if (step_a == 8'd0 || step_b == 8'd0) begin
      // top and bottom rails see one hit per period
      step = cyc;
    end else begin
      step = phase_q ? step_b : step_a;
    end
    sum  = PosW'(pos_q) + PosW'(step);
    wrap = sum >= PosW'(len_i);
  end

  assign last_k = k_q == (len_i - LenW'(1));

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    rail_d        = rail_q;
    pos_d         = pos_q;
    phase_d       = phase_q;
    wr_en_d       = 1'b0;
    out_v_d       = 1'b0;
    pop_o         = 1'b0;
    advance       = 1'b0;
    store_raddr_o = {bank_i, k_q[AddrW-1:0]};
    res_raddr     = k_q[AddrW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        k_d     = '0;
        rail_d  = '0;
        pos_d   = '0;
        phase_d = 1'b0;
        if (job_valid_i) begin
          state_d = ctrl_i.dir ? ST_SCAT : ST_EMIT;
        end
      end
      ST_SCAT: begin
        // read message byte k, write it to result slot pos next cycle
        wr_en_d = 1'b1;
        advance = 1'b1;
        k_d     = k_q + LenW'(1);
        if (last_k) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        k_d     = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ctrl_i.dir) begin
          store_raddr_o = {bank_i, pos_q};
          advance       = 1'b1;
        end
        out_v_d = 1'b1;
        k_d     = k_q + LenW'(1);
        if (last_k) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      if (wrap) begin
        rail_d  = rail_q + RailsW'(1);
        pos_d   = AddrW'(rail_q + RailsW'(1));
        phase_d = 1'b0;
      end else begin
        pos_d   = sum[AddrW-1:0];
        phase_d = !phase_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_en_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_en_q <= wr_en_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    rail_q      <= rail_d;
    pos_q       <= pos_d;
    phase_q     <= phase_d;
    wr_pos_q    <= pos_q;
    out_last_q  <= last_k;
    out_trunc_q <= ctrl_i.ovf;
    out_dir_q   <= ctrl_i.dir;
  end

  rft_ram #(
    .Width(ByteW),
    .Depth(MaxLen)
  ) u_res_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_q),
    .waddr_i(wr_pos_q),
    .wdata_i(store_rdata_i),
    .raddr_i(res_raddr),
    .rdata_o(res_rdata)
  );

  assign out_strobe_o = out_v_q;
  assign out_byte_o   = out_dir_q ? res_rdata : store_rdata_i;
  assign out_last_o   = out_last_q;
  assign truncated_o  = out_trunc_q;

endmodule

@@ src/rail_fence_transposition.sv @@
// rail fence transposition: loads a message and emits it zigzag permuted
//
// items enter on start/busy: one message byte per accepted item, in_last_i
// ends the message. config writes (rails count, direction) are taken on
// cfg_we_i and apply to messages that end after the write.
// loading writes each accepted byte into one of two message buffers. when a
// message ends, its job goes to a two-entry queue and the back end works on
// it while the next message loads into the other buffer. busy is high only
// while both buffers hold unfinished messages.
// encode: results start after the last byte is accepted and any earlier job
// is done, then one byte per cycle.
// decode: a scatter pass through a result ram and a wait state, then one
// byte per cycle.
// throughput is set by the single read port of the message buffer ram.
// each result shows on out_strobe_o for exactly one cycle; there is no
// backpressure. bytes beyond MAX_LEN are dropped and flagged on truncated_o.
// reset empties the queue and the load counter; rails resets to 2, direction
// to encode. no clearing pass is needed.
module rail_fence_transposition #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rft_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        in_last_i,
  input  logic                        cfg_we_i,
  input  logic [rft_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rft_pkg::RailsW-1:0]  cfg_wdata_i,
  output logic                        out_strobe_o,
  output logic [rft_pkg::ByteW-1:0]   out_byte_o,
  output logic                        out_last_o,
  output logic                        truncated_o
);
  import rft_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AddrW = $clog2(MAX_LEN);

  logic             push, pop, q_full, q_valid, wr_bank, rd_bank;
  logic [LenW-1:0]  push_len, head_len;
  job_ctrl_t        push_ctrl, head_ctrl;
  logic             store_we;
  logic [AddrW:0]   store_waddr, store_raddr;
  logic [ByteW-1:0] store_wdata, store_rdata;

  rft_front #(
    .MaxLen(MAX_LEN),
    .LenW  (LenW),
    .AddrW (AddrW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .bank_i       (wr_bank),
    .push_o       (push),
    .len_o        (push_len),
    .ctrl_o       (push_ctrl),
    .store_we_o   (store_we),
    .store_waddr_o(store_waddr),
    .store_wdata_o(store_wdata)
  );

  rft_job_queue #(
    .LenW(LenW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .len_i    (push_len),
    .ctrl_i   (push_ctrl),
    .pop_i    (pop),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .len_o    (head_len),
    .ctrl_o   (head_ctrl),
    .wr_bank_o(wr_bank),
    .rd_bank_o(rd_bank)
  );

  // two banks of message bytes, one per queue slot; the bank bit sits above
  // the full byte address, so each bank spans a power of two
  rft_ram #(
    .Width(ByteW),
    .Depth(2 ** (AddrW + 1))
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(store_waddr),
    .wdata_i(store_wdata),
    .raddr_i(store_raddr),
    .rdata_o(store_rdata)
  );

  rft_back #(
    .MaxLen(MAX_LEN),
    .LenW  (LenW),
    .AddrW (AddrW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .len_i        (head_len),
    .ctrl_i       (head_ctrl),
    .bank_i       (rd_bank),
    .pop_o        (pop),
    .store_raddr_o(store_raddr),
    .store_rdata_i(store_rdata),
    .out_strobe_o (out_strobe_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .truncated_o  (truncated_o)
  );

endmodule

@@ tb/sv/rft_checker.sv @@
// checker for the rail fence block: tracks config and bytes, predicts and compares results
module rft_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [rft_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        in_last_i,
  input  logic                        cfg_we_i,
  input  logic [rft_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rft_pkg::RailsW-1:0]  cfg_wdata_i,
  input  logic                        res_strobe_i,
  input  logic [rft_pkg::ByteW-1:0]   res_byte_i,
  input  logic                        res_last_i,
  input  logic                        res_trunc_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             trunc;
  } out_byte_t;

  out_byte_t         permuted_q[$];
  out_byte_t         want;
  logic [ByteW-1:0]  msg_bytes[MAX_LEN];
  int unsigned       held;
  logic              dropped;
  logic [RailsW-1:0] rails;
  logic              decode;
  int unsigned       fails;

  assign fail_count_o = fails;

  // zigzag permutation of the held message, queued in output order
  function automatic void queue_permuted(int unsigned len, int unsigned fence, logic inv,
                                         logic lost);
    int unsigned      src_pos[MAX_LEN];
    logic [ByteW-1:0] perm[MAX_LEN];
    int unsigned      k, cyc, m, on_rail;
    out_byte_t        item;
    k = 0;
    cyc = (fence > 1) ? 2 * (fence - 1) : 1;
    for (int unsigned r = 0; r < fence && k < len; r++) begin
      for (int unsigned i = 0; i < len; i++) begin
        m = i % cyc;
        on_rail = (fence <= 1) ? 0 : ((m < fence) ? m : cyc - m);
        if (on_rail == r) begin
          src_pos[k] = i;
          k++;
        end
      end
    end
    for (int unsigned j = 0; j < len; j++) begin
      if (!inv) perm[j] = msg_bytes[src_pos[j]];
      else perm[src_pos[j]] = msg_bytes[j];
    end
    for (int unsigned j = 0; j < len; j++) begin
      item.data  = perm[j];
      item.last  = (j + 1 == len);
      item.trunc = lost;
      permuted_q.push_back(item);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      permuted_q.delete();
      held      = 0;
      dropped   = 1'b0;
      rails     = RAILS_RESET;
      decode    = 1'b0;
      fails     = 0;
      pending_o <= 0;
    end else begin
      if (res_strobe_i) begin
        if (permuted_q.size() == 0) begin
          $error("unexpected result: out_byte %0h out_last %0b truncated %0b",
                 res_byte_i, res_last_i, res_trunc_i);
          fails++;
        end else begin
          want = permuted_q.pop_front();
          if (res_byte_i !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, res_byte_i);
            fails++;
          end
          if (res_last_i !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, res_last_i);
            fails++;
          end
          if (res_trunc_i !== want.trunc) begin
            $error("truncated: expected %0b, actual %0b", want.trunc, res_trunc_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAILS: rails = cfg_wdata_i;
          CFG_DIR:   decode = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (held < MAX_LEN) begin
          msg_bytes[held] = in_byte_i;
          held++;
        end else begin
          dropped = 1'b1;
        end
        if (in_last_i) begin
          // zero rails behaves as one rail
          queue_permuted(held, (rails == 0) ? 1 : int'(rails), decode, dropped);
          held    = 0;
          dropped = 1'b0;
        end
      end
      pending_o <= permuted_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the rail fence testbench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  localparam int unsigned MaxLen      = 64;
  localparam int unsigned RandomItems = 180;
  localparam int unsigned StallLimit  = 2000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [ByteW-1:0]   in_byte;
  logic               in_last;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RailsW-1:0]  cfg_wdata;
  logic               out_strobe;
  logic [ByteW-1:0]   out_byte;
  logic               out_last;
  logic               truncated;
  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        idle_cycles;
  logic               no_gaps;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rail_fence_transposition #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .out_strobe_o(out_strobe),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last),
    .truncated_o (truncated)
  );

  rft_checker #(
    .MAX_LEN(MaxLen)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .res_strobe_i(out_strobe),
    .res_byte_i  (out_byte),
    .res_last_i  (out_last),
    .res_trunc_i (truncated),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // cycles with neither an item taken nor a result shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] value, input logic ends);
    int unsigned gap, pick;
    start   <= 1'b1;
    in_byte <= value;
    in_last <= ends;
    do @(posedge clk_i); while (busy);
    gap = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 19);
      if (pick >= 18) gap = $urandom_range(8, 30);
      else if (pick >= 12) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(input int unsigned len);
    logic [ByteW-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      // newlines are plain data, so feed plenty of them
      if ($urandom_range(0, 7) == 0) b = 8'h0A;
      else b = ByteW'($urandom_range(0, 255));
      send_byte(b, i + 1 == len);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RailsW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain all results, then give the back end time to go idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       random_items, len, pick, msgs;
    logic              long_sent;
    logic [RailsW-1:0] fence;
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_byte   = '0;
    in_last   = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_RAILS;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    long_sent = 1'b0;
    random_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: two rails, encode; single byte message first
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b1);
    settle();

    write_reg(CFG_RAILS, RailsW'(3));
    write_reg(CFG_DIR, RailsW'(1));
    for (int unsigned i = 0; i < 7; i++) send_byte(ByteW'(8'h30 + i), i == 6);
    settle();

    // zero rails acts as one rail
    write_reg(CFG_RAILS, RailsW'(0));
    write_reg(CFG_DIR, RailsW'(0));
    send_byte(8'h41, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h42, 1'b1);
    settle();

    // rails above 64 with upper data bits set on the direction write
    write_reg(CFG_RAILS, RailsW'(127));
    write_reg(CFG_DIR, RailsW'(7'h7F));
    for (int unsigned i = 0; i < 4; i++) send_byte(ByteW'(8'hC0 + i), i == 3);
    settle();

    // spare indexes must leave both registers alone
    write_reg(CFG_RAILS, RailsW'(64));
    write_reg(CFG_DIR, RailsW'(0));
    write_reg(CFG_SPARE_A, RailsW'(0));
    write_reg(CFG_SPARE_B, RailsW'(7'h7F));
    for (int unsigned i = 0; i < 4; i++) send_byte(ByteW'(8'h80 >> i), i == 3);
    settle();

    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: fence = RailsW'(0);
        1: fence = RailsW'(1);
        2: fence = RailsW'(64);
        3: fence = RailsW'(127);
        4: fence = RailsW'($urandom_range(65, 126));
        default: fence = RailsW'($urandom_range(2, 12));
      endcase
      write_reg(CFG_RAILS, fence);
      write_reg(CFG_DIR, RailsW'($urandom_range(0, 127)));
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  RailsW'($urandom_range(0, 127)));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      msgs = $urandom_range(1, 4);
      for (int unsigned n = 0; n < msgs; n++) begin
        pick = $urandom_range(0, 19);
        if (!long_sent && random_items >= 60) begin
          len = MaxLen + $urandom_range(1, 6);
          long_sent = 1'b1;
        end else if (pick == 0) begin
          len = $urandom_range(40, MaxLen);
        end else if (pick == 1) begin
          len = $urandom_range(MaxLen + 1, MaxLen + 6);
        end else begin
          len = $urandom_range(1, 12);
        end
        send_message(len);
        random_items += (len > MaxLen) ? MaxLen : len;
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rft_pkg.sv
src/rft_ram.sv
src/rft_front.sv
src/rft_job_queue.sv
src/rft_back.sv
src/rail_fence_transposition.sv
tb/sv/rft_checker.sv
tb/sv/tb_top.sv
